// ----- rtl/energy_impulse_averager_core_defines.svh -----
// assertion macros shared by the core
`ifndef ENERGY_IMPULSE_AVERAGER_CORE_DEFINES_SVH
`define ENERGY_IMPULSE_AVERAGER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define EIA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define EIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/eia_pkg.sv -----
package eia_pkg;

	// widths
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int LEVEL_W         = 24;
	localparam int RUN_W           = 6;
	localparam int MAXP_W          = 7;
	localparam int CFG_W           = 24;
	localparam int CFG_IDX_W       = 2;
	localparam int STEP_W          = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 2'd2;

	// register reset values
	localparam logic [LEVEL_W-1:0] THR_RST  = 24'd12500;
	localparam logic [RUN_W-1:0]   MINP_RST = 6'd3;
	localparam logic [MAXP_W-1:0]  MAXP_RST = 7'd25;

	// cap on the max period register; a segment stays shorter than it so it fits the run counter
	localparam logic [MAXP_W-1:0] RUN_CAP = 7'd64;

	// microprogram step addresses
	localparam logic [STEP_W-1:0] STEP_FETCH  = 2'd0;
	localparam logic [STEP_W-1:0] STEP_DECIDE = 2'd1;
	localparam logic [STEP_W-1:0] STEP_DIV    = 2'd2;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 2'd3;

	typedef struct packed {
		logic [LEVEL_W-1:0] energy;
		logic               final_sample;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               in_impulse;
		logic               last_of_burst;
		logic               end_of_data;
	} out_item_t;

	// datapath controls driven by the current control word
	typedef struct packed {
		logic take_req;
		logic decide;
		logic div_step;
		logic emit;
	} ctl_t;

	// datapath status used for conditional jumps
	typedef struct packed {
		logic req_acc;
		logic no_burst;
		logic div_busy;
		logic emit_busy;
	} sts_t;

	typedef enum logic [1:0] {
		COND_NO_REQ,
		COND_NO_BURST,
		COND_DIV_BUSY,
		COND_EMIT_BUSY
	} cond_t;

	typedef struct packed {
		ctl_t              ctl;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

endpackage

// ----- rtl/eia_stream_if.sv -----
interface eia_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/eia_seq.sv -----
module eia_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  eia_pkg::sts_t sts,
	output eia_pkg::ctl_t ctl
);

	logic [eia_pkg::STEP_W-1:0] step_q;
	logic [eia_pkg::STEP_W-1:0] step_nxt;
	eia_pkg::uword_t            uw;
	logic                       cond_hit;

	// control store: jump to target when the condition holds, else fall through
	function automatic eia_pkg::uword_t ucode(input logic [eia_pkg::STEP_W-1:0] addr);
		eia_pkg::uword_t w;
		w = '0;
		case (addr)
			eia_pkg::STEP_FETCH: begin
				w.ctl.take_req = 1'b1;
				w.cond         = eia_pkg::COND_NO_REQ;
				w.target       = eia_pkg::STEP_FETCH;
			end
			eia_pkg::STEP_DECIDE: begin
				w.ctl.decide = 1'b1;
				w.cond       = eia_pkg::COND_NO_BURST;
				w.target     = eia_pkg::STEP_FETCH;
			end
			eia_pkg::STEP_DIV: begin
				w.ctl.div_step = 1'b1;
				w.cond         = eia_pkg::COND_DIV_BUSY;
				w.target       = eia_pkg::STEP_DIV;
			end
			eia_pkg::STEP_EMIT: begin
				w.ctl.emit = 1'b1;
				w.cond     = eia_pkg::COND_EMIT_BUSY;
				w.target   = eia_pkg::STEP_EMIT;
			end
			default: begin
				w.cond   = eia_pkg::COND_NO_REQ;
				w.target = eia_pkg::STEP_FETCH;
			end
		endcase
		return w;
	endfunction

	always_comb begin
		uw = ucode(step_q);
		case (uw.cond)
			eia_pkg::COND_NO_REQ:    cond_hit = !sts.req_acc;
			eia_pkg::COND_NO_BURST:  cond_hit = sts.no_burst;
			eia_pkg::COND_DIV_BUSY:  cond_hit = sts.div_busy;
			eia_pkg::COND_EMIT_BUSY: cond_hit = sts.emit_busy;
			default:                 cond_hit = 1'b0;
		endcase
		// last step wraps back to fetch
		step_nxt = cond_hit ? uw.target : step_q + eia_pkg::STEP_W'(1);
		ctl      = uw.ctl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= eia_pkg::STEP_FETCH;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

// ----- rtl/eia_datapath.sv -----
module eia_datapath #(
	parameter int SAMPLE_BITS = eia_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [eia_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [eia_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  eia_pkg::in_item_t             in_item,
	input  logic                          out_ready,
	output logic                          out_valid,
	output eia_pkg::out_item_t            out_item,
	input  eia_pkg::ctl_t                 ctl,
	output eia_pkg::sts_t                 sts
);

	localparam int RUN_W  = eia_pkg::RUN_W;
	localparam int MAXP_W = eia_pkg::MAXP_W;
	localparam int LVL_W  = eia_pkg::LEVEL_W;
	localparam int SUM_W  = SAMPLE_BITS + RUN_W;
	localparam int CMP_W  = (SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W;
	localparam int CNT_W  = $clog2(SUM_W + 1);

	// configuration
	logic [LVL_W-1:0]  thr_q;
	logic [RUN_W-1:0]  min_q;
	logic [MAXP_W-1:0] max_q;

	// current request
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   fin_q;

	// open run
	logic [RUN_W-1:0] len_q;
	logic [SUM_W-1:0] sum_q;
	logic             rej_q;

	// burst and divider
	logic [RUN_W-1:0] burst_q;
	logic             imp_q;
	logic [SUM_W-1:0] quo_q;
	logic [RUN_W-1:0] rem_q;
	logic [RUN_W-1:0] den_q;
	logic [CNT_W-1:0] dcnt_q;
	logic             div_run_q;

	logic                out_valid_q;
	eia_pkg::out_item_t  out_q;

	logic              active;
	logic [MAXP_W-1:0] eff_max;
	logic [MAXP_W-1:0] run_inc;
	logic [SUM_W-1:0]  sum_tot;
	logic [RUN_W-1:0]  d_burst;
	logic              d_div;
	logic [RUN_W-1:0]  d_len;
	logic [SUM_W-1:0]  d_sum;
	logic              d_rej;
	logic [RUN_W:0]    trial;
	logic              trial_ge;
	logic              load;
	logic              req_acc;

	assign active  = CMP_W'(sample_q) > CMP_W'(thr_q);
	assign eff_max = (max_q > eia_pkg::RUN_CAP) ? eia_pkg::RUN_CAP : max_q;
	assign run_inc = {1'b0, len_q} + MAXP_W'(1);
	assign sum_tot = sum_q + SUM_W'(sample_q);

	// segment decision for the latched sample
	always_comb begin
		d_burst = '0;
		d_div   = 1'b0;
		d_len   = len_q;
		d_sum   = sum_q;
		d_rej   = rej_q;
		if (rej_q) begin
			d_burst = RUN_W'(1);
			d_rej   = active;
		end else if (active) begin
			if (fin_q || (run_inc + MAXP_W'(1) >= eff_max)) begin
				d_burst = run_inc[RUN_W-1:0];
				d_len   = '0;
				d_sum   = '0;
				d_rej   = !fin_q;
			end else begin
				d_len = run_inc[RUN_W-1:0];
				d_sum = sum_tot;
			end
		end else if (len_q == '0) begin
			d_burst = RUN_W'(1);
		end else begin
			d_burst = run_inc[RUN_W-1:0];
			d_div   = (run_inc > {1'b0, min_q}) && (run_inc < eff_max);
			d_len   = '0;
			d_sum   = '0;
			d_rej   = 1'b0;
		end
		if (fin_q) begin
			d_len = '0;
			d_sum = '0;
			d_rej = 1'b0;
		end
	end

	// restoring divide, one quotient bit per step
	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign trial_ge = trial >= {1'b0, den_q};

	assign req_acc = ctl.take_req && in_valid;
	assign load    = ctl.emit && (!out_valid_q || out_ready);

	always_comb begin
		sts.req_acc   = req_acc;
		sts.no_burst  = (d_burst == '0);
		sts.div_busy  = div_run_q && (dcnt_q != CNT_W'(1));
		sts.emit_busy = !(load && (burst_q == RUN_W'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= eia_pkg::THR_RST;
			min_q <= eia_pkg::MINP_RST;
			max_q <= eia_pkg::MAXP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				eia_pkg::REG_THRESHOLD:  thr_q <= cfg_data;
				eia_pkg::REG_MIN_PERIOD: min_q <= cfg_data[RUN_W-1:0];
				eia_pkg::REG_MAX_PERIOD: max_q <= cfg_data[MAXP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			sum_q       <= '0;
			rej_q       <= 1'b0;
			burst_q     <= '0;
			imp_q       <= 1'b0;
			div_run_q   <= 1'b0;
			dcnt_q      <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				fin_q <= in_item.final_sample;
			end
			if (ctl.decide) begin
				len_q   <= d_len;
				sum_q   <= d_sum;
				rej_q   <= d_rej;
				burst_q <= d_burst;
				imp_q   <= d_div;
				if (d_div) begin
					div_run_q <= 1'b1;
					dcnt_q    <= CNT_W'(SUM_W);
				end
			end
			if (ctl.div_step && div_run_q) begin
				dcnt_q <= dcnt_q - CNT_W'(1);
				if (dcnt_q == CNT_W'(1)) begin
					div_run_q <= 1'b0;
				end
			end
			if (load) begin
				burst_q     <= burst_q - RUN_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			sample_q <= SAMPLE_BITS'(in_item.energy);
		end
		if (ctl.decide && d_div) begin
			quo_q <= sum_tot;
			rem_q <= '0;
			den_q <= run_inc[RUN_W-1:0];
		end
		if (ctl.div_step && div_run_q) begin
			rem_q <= trial_ge ? RUN_W'(trial - {1'b0, den_q}) : trial[RUN_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], trial_ge};
		end
		if (load) begin
			out_q.level         <= imp_q ? LVL_W'(quo_q) : '0;
			out_q.in_impulse    <= imp_q;
			out_q.last_of_burst <= (burst_q == RUN_W'(1));
			out_q.end_of_data   <= (burst_q == RUN_W'(1)) && fin_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ----- rtl/energy_impulse_averager_core.sv -----
// channel    dir  payload                                              request taken when
// samples    in   energy[23:0], final_sample                           valid && ready
// results    out  level[23:0], in_impulse, last_of_burst, end_of_data  valid && ready
// cfg        in   cfg_index[1:0], cfg_data[23:0]                       cfg_wr_en
//
// steps: a sample that closes nothing passes fetch and decide only; a sample that
//   releases results also passes the divide step, which repeats while the
//   bit-serial divider works out the average of an impulse, then the emit step once per result
// the microprogram has four steps; the divider makes one quotient bit per cycle
// reset: arst_n clears the run state and loads the register defaults; no clearing pass
// stalls: a held results channel freezes the emit step; the last result of a burst
//   waits in the output register while the next sample request is taken
`include "energy_impulse_averager_core_defines.svh"

module energy_impulse_averager_core #(
	parameter int SAMPLE_BITS = eia_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [eia_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [eia_pkg::CFG_W-1:0]     cfg_data,
	eia_stream_if.sink                    samples,
	eia_stream_if.source                  results
);

	// control word from the sequencer, status back for its jumps
	eia_pkg::ctl_t      ctl;
	eia_pkg::sts_t      sts;
	eia_pkg::in_item_t  in_item;
	eia_pkg::out_item_t out_item;
	logic               out_valid;

	assign in_item.energy       = samples.data.energy;
	assign in_item.final_sample = samples.data.final_sample;

	// sequencer: step counter walking the control store
	eia_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// datapath: run state, divider, output register
	eia_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (samples.valid),
		.in_item   (in_item),
		.out_ready (results.ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.ctl       (ctl),
		.sts       (sts)
	);

	// ready only in the fetch step
	assign samples.ready = ctl.take_req;

	assign results.valid              = out_valid;
	assign results.data.level         = out_item.level;
	assign results.data.in_impulse    = out_item.in_impulse;
	assign results.data.last_of_burst = out_item.last_of_burst;
	assign results.data.end_of_data   = out_item.end_of_data;

	// a taken sample is always followed by a decide step, never a second fetch
	`EIA_ASSERT_NEXT(a_fetch_then_decide, clk, arst_n, sts.req_acc, !samples.ready)
	// results outside an impulse carry zero level
	`EIA_ASSERT_SAME(a_zero_outside, clk, arst_n, results.valid && !results.data.in_impulse, results.data.level == '0)
	// end of data only on the closing result of a burst
	`EIA_ASSERT_SAME(a_eod_last, clk, arst_n, results.valid && results.data.end_of_data, results.data.last_of_burst)

endmodule
